### rtl/core/bctd_pkg.sv
// Package for the battery charge trend detector: word types, sequencer states,
// register indexes, trend codes and thresholds. No dependencies.
package bctd_pkg;

  localparam int DEF_SAMPLE_DEPTH = 32;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] battery_millivolts;
    logic        sample_ok;
    logic [7:0]  backlight_level;
  } in_word_t;

  typedef struct packed {
    logic       charging;
    logic [2:0] trend_state;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REC, ST_ANCHOR, ST_AMED, ST_FIRST, ST_FALLS, ST_DECIDE, ST_OUT
  } seq_state_t;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MIN_MV     = 3'd0;
  localparam logic [2:0] REG_MAX_MV     = 3'd1;
  localparam logic [2:0] REG_FAILSAFE   = 3'd2;
  localparam logic [2:0] REG_CHG_SETTLE = 3'd3;
  localparam logic [2:0] REG_NRM_SETTLE = 3'd4;

  // trend codes
  localparam logic [2:0] TR_UNKNOWN  = 3'd0;
  localparam logic [2:0] TR_BATTERY  = 3'd1;
  localparam logic [2:0] TR_CHG_CAND = 3'd2;
  localparam logic [2:0] TR_CHARGING = 3'd3;
  localparam logic [2:0] TR_UNPLUG   = 3'd4;

  localparam logic [31:0] WIN_FAST_MS  = 32'd30000;
  localparam logic [31:0] WIN_SLOW_MS  = 32'd90000;
  localparam logic [31:0] STALE_MS     = 32'd30000;
  localparam logic [16:0] FALL_DELTA   = 17'd35;
  localparam logic [16:0] RISE_FAST    = 17'd35;
  localparam logic [16:0] RISE_SLOW    = 17'd25;
  localparam logic [16:0] PEAK_DROP    = 17'd45;
  localparam logic [16:0] STEP_SLACK   = 17'd8;
  localparam logic [16:0] CAND_SLACK   = 17'd8;
  localparam int          STEADY_MIN   = 12;
  localparam logic [3:0]  FALL_NUM     = 4'd10;
  localparam logic [3:0]  FALL_DEN     = 4'd3;
  localparam logic [1:0]  EVID_MAX     = 2'd3;

  localparam logic [15:0] RST_MIN_MV     = 16'd3000;
  localparam logic [15:0] RST_MAX_MV     = 16'd4400;
  localparam logic [19:0] RST_FAILSAFE   = 20'd10000;
  localparam logic [19:0] RST_CHG_SETTLE = 20'd15000;
  localparam logic [19:0] RST_NRM_SETTLE = 20'd45000;

  function automatic logic [15:0] mid3(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c);
    logic [15:0] x, y, z, t;
    x = a; y = b; z = c;
    if (x > y) begin t = x; x = y; y = t; end
    if (y > z) begin t = y; y = z; z = t; end
    if (x > y) begin t = x; x = y; y = t; end
    return y;
  endfunction

  function automatic logic [1:0] bump(input logic [1:0] e);
    return (e == EVID_MAX) ? EVID_MAX : e + 2'd1;
  endfunction

endpackage

### rtl/core/battery_charge_trend_detector_unit.sv
// Battery charge trend detector: top level with sample store memory,
// scan sequencer and configuration registers. Uses bctd_pkg.
// A word that is dropped or gated goes straight to the result hand-off (ST_OUT); any
//   other word passes at most the recent median, two anchor scans and the rise scans.
// One word at a time: in_stall holds the next word until the result of the last is
//   handed off, and the single read port of the store sets how long the scans take.
// Reset (rst, synchronous): control state and registers to their defaults; the store
//   is not cleared, only entries below the fill count are read.
module battery_charge_trend_detector_unit
  import bctd_pkg::*;
#(
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    sample,
  output logic        result_valid,
  input  logic        result_stall,
  output out_word_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW = $clog2(SAMPLE_DEPTH);
  localparam int FW = $clog2(SAMPLE_DEPTH + 1);
  localparam logic [LW:0] DEPTH_W = (LW + 1)'(SAMPLE_DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(SAMPLE_DEPTH);
  localparam logic [FW-1:0] STEADY_F = FW'(STEADY_MIN);

  // configuration
  logic [15:0] min_mv, max_mv;
  logic [19:0] failsafe_ms, chg_settle_ms, nrm_settle_ms;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_mv        <= RST_MIN_MV;
      max_mv        <= RST_MAX_MV;
      failsafe_ms   <= RST_FAILSAFE;
      chg_settle_ms <= RST_CHG_SETTLE;
      nrm_settle_ms <= RST_NRM_SETTLE;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MIN_MV:     min_mv        <= pwdata[15:0];
        REG_MAX_MV:     max_mv        <= pwdata[15:0];
        REG_FAILSAFE:   failsafe_ms   <= pwdata[19:0];
        REG_CHG_SETTLE: chg_settle_ms <= pwdata[19:0];
        REG_NRM_SETTLE: nrm_settle_ms <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MIN_MV:     prdata = {16'd0, min_mv};
      REG_MAX_MV:     prdata = {16'd0, max_mv};
      REG_FAILSAFE:   prdata = {12'd0, failsafe_ms};
      REG_CHG_SETTLE: prdata = {12'd0, chg_settle_ms};
      REG_NRM_SETTLE: prdata = {12'd0, nrm_settle_ms};
      default:        prdata = 32'd0;
    endcase
  end

  // sample store: {time, millivolts}, circular from head
  logic [47:0]   mem [SAMPLE_DEPTH];
  logic [47:0]   rdata;
  logic [LW-1:0] raddr, waddr;
  logic          wen;
  logic [47:0]   wdata;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // state
  seq_state_t    state, state_next;
  logic [FW-1:0] fill, fill_next, cnt, cnt_next, pidx, pidx_next;
  logic [FW-1:0] anchor, anchor_next, first, first_next, falls, falls_next;
  logic [LW-1:0] head, head_next;
  logic          pv, pv_next;
  logic [1:0]    rise_ev, rise_ev_next, fall_ev, fall_ev_next;
  logic [15:0]   peak, peak_next, cand, cand_next, recent, recent_next;
  logic [15:0]   m1, m1_next, m2, m2_next, prev_mv, prev_mv_next;
  logic          load_seen, load_seen_next, load_changed, load_changed_next;
  logic [7:0]    last_level, last_level_next;
  logic [31:0]   load_change_time, load_change_time_next;
  logic          settle_chg, settle_chg_next, invalid_run, invalid_run_next;
  logic [31:0]   invalid_start, invalid_start_next, now_ms, now_ms_next;
  logic          is_charging, is_charging_next;
  logic [2:0]    cur_state, cur_state_next;
  logic          use90, use90_next, d30_fall, d30_fall_next, d30_rise, d30_rise_next;
  logic          slow_hit, slow_hit_next;
  logic          res_valid, res_valid_next;
  out_word_t     res, res_next;

  function automatic logic [LW-1:0] phys(input logic [LW-1:0] h, input logic [FW-1:0] li);
    logic [LW:0] s;
    s = {1'b0, h} + {1'b0, li[LW-1:0]};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[LW-1:0];
  endfunction

  assign in_stall     = (state != ST_IDLE);
  assign result_valid = res_valid;
  assign result       = res;

  always_comb begin
    logic        drop, ok, leave, ren;
    logic [31:0] age, win, settle;
    logic [15:0] rmv, med;
    logic [16:0] delta;
    logic [FW-1:0] fsum, steps;
    logic [FW+3:0] lhs, rhs;
    logic        falling, fast;

    state_next = state;        fill_next = fill;       cnt_next = cnt;
    pidx_next = cnt;           anchor_next = anchor;   first_next = first;
    falls_next = falls;        head_next = head;       pv_next = 1'b0;
    rise_ev_next = rise_ev;    fall_ev_next = fall_ev; peak_next = peak;
    cand_next = cand;          recent_next = recent;   m1_next = m1;
    m2_next = m2;              prev_mv_next = prev_mv; load_seen_next = load_seen;
    load_changed_next = load_changed;   last_level_next = last_level;
    load_change_time_next = load_change_time;       settle_chg_next = settle_chg;
    invalid_run_next = invalid_run;     invalid_start_next = invalid_start;
    now_ms_next = now_ms;      is_charging_next = is_charging;
    cur_state_next = cur_state; use90_next = use90;   d30_fall_next = d30_fall;
    d30_rise_next = d30_rise;  slow_hit_next = slow_hit;
    res_valid_next = res_valid && result_stall;
    res_next = res;
    wen = 1'b0; waddr = '0; wdata = {sample.time_ms, sample.battery_millivolts};
    drop = 1'b0; ok = 1'b0; leave = 1'b0; ren = 1'b0;
    rmv = rdata[15:0];
    age = now_ms - rdata[47:16];
    win = use90 ? WIN_SLOW_MS : WIN_FAST_MS;
    settle = '0; med = '0; delta = '0; fsum = '0; steps = '0; lhs = '0; rhs = '0;
    falling = 1'b0; fast = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          now_ms_next = sample.time_ms;
          d30_fall_next = 1'b0; d30_rise_next = 1'b0; slow_hit_next = 1'b0;
          use90_next = 1'b0;
          state_next = ST_OUT;
          if (!load_seen) begin
            load_seen_next = 1'b1;
            last_level_next = sample.backlight_level;
            drop = 1'b1;
          end else if (sample.backlight_level != last_level) begin
            last_level_next = sample.backlight_level;
            load_changed_next = 1'b1;
            load_change_time_next = sample.time_ms;
            settle_chg_next = is_charging;
            drop = 1'b1;
            cur_state_next = is_charging ? TR_CHARGING : TR_UNKNOWN;
          end
          ok = sample.sample_ok && sample.battery_millivolts >= min_mv &&
               sample.battery_millivolts <= max_mv;
          settle = settle_chg_next ? {12'd0, chg_settle_ms} : {12'd0, nrm_settle_ms};
          if (!ok) begin
            if (!invalid_run) begin
              invalid_run_next = 1'b1;
              invalid_start_next = sample.time_ms;
            end else if (sample.time_ms - invalid_start >= {12'd0, failsafe_ms}) begin
              is_charging_next = 1'b0;
              cur_state_next = TR_UNKNOWN;
              drop = 1'b1;
            end
          end else begin
            invalid_run_next = 1'b0;
            if (!(load_changed_next &&
                  sample.time_ms - load_change_time_next < settle)) begin
              fsum = drop ? '0 : fill;
              wen = 1'b1;
              if (fsum >= DEPTH_F) begin
                // full: overwrite the oldest entry and advance the head
                waddr = head;
                head_next = (head == LW'(SAMPLE_DEPTH - 1)) ? '0 : head + 1'b1;
                fill_next = DEPTH_F;
              end else begin
                waddr = phys(head, fsum);
                fill_next = fsum + 1'b1;
              end
              if (fill_next < FW'(3)) begin
                cur_state_next = is_charging_next ? TR_CHARGING : TR_UNKNOWN;
              end else begin
                state_next = ST_REC;
                cnt_next = fill_next - FW'(3);
              end
            end
          end
          if (drop && !wen) begin
            fill_next = '0;
          end
          if (drop) begin
            rise_ev_next = '0; fall_ev_next = '0; peak_next = '0; cand_next = '0;
          end
        end
      end

      ST_REC: begin
        ren = (cnt != fill);
        if (pv) begin
          m1_next = m2; m2_next = rmv;
          if (pidx == fill - 1'b1) begin
            med = mid3(m1, m2, rmv);
            recent_next = med;
            if (is_charging && med > peak) peak_next = med;
            leave = 1'b1;
            if (fill >= FW'(6)) begin
              state_next = ST_ANCHOR;
              cnt_next = fill - FW'(3);
            end else begin
              state_next = ST_DECIDE;
            end
          end
        end
      end

      ST_ANCHOR: begin
        ren = (cnt >= FW'(2));
        if (pv) begin
          if (age >= win || pidx == FW'(2)) begin
            leave = 1'b1;
            if (age >= win && age <= win + STALE_MS) begin
              anchor_next = pidx;
              cnt_next = pidx - FW'(2);
              state_next = ST_AMED;
            end else if (!use90 && !is_charging) begin
              use90_next = 1'b1;
              cnt_next = fill - FW'(3);
            end else begin
              state_next = ST_DECIDE;
            end
          end
        end
      end

      ST_AMED: begin
        ren = (cnt <= anchor);
        if (pv) begin
          m1_next = m2; m2_next = rmv;
          if (pidx == anchor) begin
            med = mid3(m1, m2, rmv);
            delta = {1'b0, recent} - {1'b0, med};
            leave = 1'b1;
            if (!use90) begin
              d30_fall_next = $signed(delta) <= -$signed(FALL_DELTA);
              d30_rise_next = $signed(delta) >= $signed(RISE_FAST);
              if (is_charging) begin
                state_next = ST_DECIDE;
              end else begin
                use90_next = 1'b1;
                cnt_next = fill - FW'(3);
                state_next = ST_ANCHOR;
              end
            end else if ($signed(delta) >= $signed(RISE_SLOW)) begin
              cnt_next = '0;
              state_next = ST_FIRST;
            end else begin
              state_next = ST_DECIDE;
            end
          end
        end
      end

      ST_FIRST: begin
        ren = (cnt != fill);
        if (pv) begin
          if (age <= WIN_SLOW_MS) begin
            leave = 1'b1;
            first_next = pidx;
            if (fill - pidx < STEADY_F) begin
              state_next = ST_DECIDE;
            end else begin
              cnt_next = pidx;
              falls_next = '0;
              state_next = ST_FALLS;
            end
          end else if (pidx == fill - 1'b1) begin
            leave = 1'b1;
            state_next = ST_DECIDE;
          end
        end
      end

      ST_FALLS: begin
        ren = (cnt != fill);
        if (pv) begin
          prev_mv_next = rmv;
          if (pidx != first && {1'b0, rmv} + STEP_SLACK < {1'b0, prev_mv}) begin
            falls_next = falls + 1'b1;
          end
          if (pidx == fill - 1'b1) begin
            leave = 1'b1;
            steps = fill - 1'b1 - first;
            lhs = (FW + 4)'(falls_next) * (FW + 4)'(FALL_NUM);
            rhs = (FW + 4)'(steps) * (FW + 4)'(FALL_DEN);
            slow_hit_next = (steps != '0) && (lhs <= rhs);
            state_next = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        state_next = ST_OUT;
        if (is_charging) begin
          falling = d30_fall || ({1'b0, peak} >= {1'b0, recent} + PEAK_DROP);
          if (falling) begin
            fall_ev_next = bump(fall_ev);
            cur_state_next = TR_UNPLUG;
          end else begin
            fall_ev_next = '0;
            cur_state_next = TR_CHARGING;
          end
          if (fall_ev_next == EVID_MAX) begin
            is_charging_next = 1'b0;
            cur_state_next = TR_BATTERY;
            fill_next = '0; rise_ev_next = '0; fall_ev_next = '0;
            peak_next = '0; cand_next = '0;
          end
        end else begin
          fast = d30_rise;
          if (fast || slow_hit) begin
            if (rise_ev == '0) cand_next = recent;
            rise_ev_next = bump(rise_ev);
            cur_state_next = TR_CHG_CAND;
          end else if (rise_ev != '0 && {1'b0, recent} + CAND_SLACK >= {1'b0, cand}) begin
            rise_ev_next = bump(rise_ev);
            cur_state_next = TR_CHG_CAND;
          end else begin
            rise_ev_next = '0;
            cand_next = '0;
            cur_state_next = TR_BATTERY;
          end
          if (rise_ev_next == EVID_MAX) begin
            is_charging_next = 1'b1;
            cur_state_next = TR_CHARGING;
            peak_next = recent;
            fall_ev_next = '0;
          end
        end
      end

      ST_OUT: begin
        if (!res_valid || !result_stall) begin
          res_valid_next = 1'b1;
          res_next.charging = is_charging;
          res_next.trend_state = cur_state;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    if (state == ST_ANCHOR) begin
      if (ren) cnt_next = leave ? cnt_next : cnt - 1'b1;
    end else if (ren && !leave) begin
      cnt_next = cnt + 1'b1;
    end
    pv_next = ren && !leave;
    raddr = phys(head, cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0; head <= '0; pv <= 1'b0;
      rise_ev <= '0; fall_ev <= '0; peak <= '0; cand <= '0;
      load_seen <= 1'b0; load_changed <= 1'b0; last_level <= '0;
      load_change_time <= '0; settle_chg <= 1'b0;
      invalid_run <= 1'b0; invalid_start <= '0;
      is_charging <= 1'b0; cur_state <= TR_UNKNOWN;
      use90 <= 1'b0; d30_fall <= 1'b0; d30_rise <= 1'b0; slow_hit <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill <= fill_next; head <= head_next; pv <= pv_next;
      rise_ev <= rise_ev_next; fall_ev <= fall_ev_next;
      peak <= peak_next; cand <= cand_next;
      load_seen <= load_seen_next; load_changed <= load_changed_next;
      last_level <= last_level_next; load_change_time <= load_change_time_next;
      settle_chg <= settle_chg_next;
      invalid_run <= invalid_run_next; invalid_start <= invalid_start_next;
      is_charging <= is_charging_next; cur_state <= cur_state_next;
      use90 <= use90_next; d30_fall <= d30_fall_next; d30_rise <= d30_rise_next;
      slow_hit <= slow_hit_next;
      res_valid <= res_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt <= cnt_next; pidx <= pidx_next; anchor <= anchor_next;
    first <= first_next; falls <= falls_next;
    recent <= recent_next; m1 <= m1_next; m2 <= m2_next; prev_mv <= prev_mv_next;
    now_ms <= now_ms_next; res <= res_next;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= DEPTH_F)
    else $error("fill count beyond store depth");
  a_decide_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE |=> state == ST_OUT)
    else $error("decision not followed by result hand-off");
  a_read_live: assert property (@(posedge clk) disable iff (rst)
    pv |-> (state == ST_REC || state == ST_ANCHOR || state == ST_AMED ||
            state == ST_FIRST || state == ST_FALLS))
    else $error("store read pending outside a scan");
  a_evid_excl: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && is_charging |-> rise_ev == EVID_MAX || rise_ev == '0
      || fall_ev == '0 || !is_charging || fall_ev != EVID_MAX)
    else $error("fall evidence saturated while still charging");

endmodule

### tb/bctd_trend_model.sv
// Scoreboard class for the battery charge trend detector testbench: predicts the
// charging decision and trend code of every accepted sample word. Uses bctd_pkg.
`timescale 1ns / 100ps

package bctd_trend_model_pkg;
  import bctd_pkg::*;

  localparam int DEPTH = DEF_SAMPLE_DEPTH;

  class trend_scoreboard;
    logic [15:0] min_mv, max_mv;
    logic [19:0] failsafe_ms, chg_settle_ms, nrm_settle_ms;
    logic [31:0] times [DEPTH];
    logic [15:0] volts [DEPTH];
    int unsigned fill;
    logic [1:0]  rise_ev, fall_ev;
    logic [31:0] peak_mv, cand_mv;
    bit          load_seen, load_changed, settle_chg, inv_run, chg;
    logic [7:0]  last_level;
    logic [31:0] load_time, inv_start;
    logic [2:0]  trend;
    out_word_t   pending [$];
    int          errors;

    function new();
      min_mv = RST_MIN_MV; max_mv = RST_MAX_MV; failsafe_ms = RST_FAILSAFE;
      chg_settle_ms = RST_CHG_SETTLE; nrm_settle_ms = RST_NRM_SETTLE;
      clear_store();
      load_seen = 0; load_changed = 0; settle_chg = 0; inv_run = 0; chg = 0;
      last_level = 0; load_time = 0; inv_start = 0; trend = TR_UNKNOWN;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MIN_MV:     min_mv = val[15:0];
        REG_MAX_MV:     max_mv = val[15:0];
        REG_FAILSAFE:   failsafe_ms = val[19:0];
        REG_CHG_SETTLE: chg_settle_ms = val[19:0];
        REG_NRM_SETTLE: nrm_settle_ms = val[19:0];
        default: ;
      endcase
    endfunction

    function void clear_store();
      fill = 0; rise_ev = 0; fall_ev = 0; peak_mv = 0; cand_mv = 0;
    endfunction

    function logic [31:0] med3(int unsigned i);
      logic [15:0] a, b, c, t;
      a = volts[i-2]; b = volts[i-1]; c = volts[i];
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
      return {16'd0, b};
    endfunction

    function bit anchor_shift(logic [31:0] now, logic [31:0] win, output int d);
      int i;
      int unsigned anchor;
      logic [31:0] age;
      anchor = fill;
      d = 0;
      if (fill < 6) return 0;
      for (i = fill - 3; i >= 2; i--) begin
        age = now - times[i];
        if (age >= win) begin
          if (age <= win + 32'd30000) anchor = i;
          break;
        end
      end
      if (anchor == fill) return 0;
      d = int'(med3(fill - 1)) - int'(med3(anchor));
      return 1;
    endfunction

    function bit rising_steadily(logic [31:0] now, logic [31:0] win);
      int unsigned first, steps, falls;
      first = 0; steps = 0; falls = 0;
      while (first < fill && (now - times[first]) > win) first++;
      if (fill - first < 12) return 0;
      for (int unsigned i = first + 1; i < fill; i++) begin
        steps++;
        if ({16'd0, volts[i]} + 32'd8 < {16'd0, volts[i-1]}) falls++;
      end
      return steps != 0 && falls * 10 <= steps * 3;
    endfunction

    function logic [1:0] sat_inc(logic [1:0] e);
      return (e == 2'd3) ? 2'd3 : e + 2'd1;
    endfunction

    function void advance(logic [31:0] now, logic [15:0] mv, bit ok, logic [7:0] lvl);
      logic [31:0] recent, settle;
      int d30, d90;
      bit have, falling, fast, slow;
      if (!load_seen) begin
        load_seen = 1; last_level = lvl; clear_store();
      end else if (lvl != last_level) begin
        last_level = lvl; load_changed = 1; load_time = now; settle_chg = chg;
        clear_store();
        trend = chg ? TR_CHARGING : TR_UNKNOWN;
      end
      if (!(ok && mv >= min_mv && mv <= max_mv)) begin
        if (!inv_run) begin
          inv_run = 1; inv_start = now;
        end else if (now - inv_start >= {12'd0, failsafe_ms}) begin
          chg = 0; trend = TR_UNKNOWN; clear_store();
        end
        return;
      end
      inv_run = 0;
      settle = settle_chg ? {12'd0, chg_settle_ms} : {12'd0, nrm_settle_ms};
      if (load_changed && (now - load_time) < settle) return;
      if (fill >= DEPTH) begin
        for (int k = 0; k < DEPTH - 1; k++) begin
          times[k] = times[k+1]; volts[k] = volts[k+1];
        end
        fill = DEPTH - 1;
      end
      times[fill] = now; volts[fill] = mv; fill++;
      if (fill < 3) begin
        trend = chg ? TR_CHARGING : TR_UNKNOWN;
        return;
      end
      recent = med3(fill - 1);
      if (chg) begin
        if (recent > peak_mv) peak_mv = recent;
        have = anchor_shift(now, 32'd30000, d30);
        falling = (have && d30 <= -35) || (peak_mv >= recent + 32'd45);
        if (falling) begin
          fall_ev = sat_inc(fall_ev); trend = TR_UNPLUG;
        end else begin
          fall_ev = 0; trend = TR_CHARGING;
        end
        if (fall_ev >= 2'd3) begin
          chg = 0; trend = TR_BATTERY; clear_store();
        end
        return;
      end
      fast = anchor_shift(now, 32'd30000, d30) && d30 >= 35;
      slow = anchor_shift(now, 32'd90000, d90) && d90 >= 25 &&
             rising_steadily(now, 32'd90000);
      if (fast || slow) begin
        if (rise_ev == 0) cand_mv = recent;
        rise_ev = sat_inc(rise_ev); trend = TR_CHG_CAND;
      end else if (rise_ev != 0 && recent + 32'd8 >= cand_mv) begin
        rise_ev = sat_inc(rise_ev); trend = TR_CHG_CAND;
      end else begin
        rise_ev = 0; cand_mv = 0; trend = TR_BATTERY;
      end
      if (rise_ev >= 2'd3) begin
        chg = 1; trend = TR_CHARGING; peak_mv = recent; fall_ev = 0;
      end
    endfunction

    function void note_sample(in_word_t w);
      out_word_t o;
      advance(w.time_ms, w.battery_millivolts, w.sample_ok, w.backlight_level);
      o.charging = chg;
      o.trend_state = trend;
      pending.push_back(o);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected result word charging=%0d trend_state=%0d",
               got.charging, got.trend_state);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.charging !== exp_w.charging) begin
        $error("charging: expected %0d actual %0d", exp_w.charging, got.charging);
        errors++;
      end
      if (got.trend_state !== exp_w.trend_state) begin
        $error("trend_state: expected %0d actual %0d", exp_w.trend_state, got.trend_state);
        errors++;
      end
    endfunction
  endclass
endpackage

### tb/tb_battery_charge_trend_detector_unit.sv
// Top of the battery charge trend detector testbench: drives sample words and
// register writes, checks result words. Uses bctd_pkg and bctd_trend_model_pkg.
`timescale 1ns / 100ps

module tb_battery_charge_trend_detector_unit;
  import bctd_pkg::*;
  import bctd_trend_model_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  in_word_t    sample = '0;
  logic        result_valid;
  logic        result_stall = 0;
  out_word_t   result;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  trend_scoreboard sb;
  int          cycles = 0;
  bit          hold_off = 0;
  logic [31:0] clock_ms = 0;
  logic [7:0]  cur_level = 0;
  logic [15:0] base_mv = 3700;

  battery_charge_trend_detector_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // note each accepted sample word
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_sample(sample);
  end

  // result side: check, and stall at random
  initial begin
    int n;
    sb = new();
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
      if (hold_off) result_stall <= 1;
      else if (result_valid && !result_stall || n == 0) begin
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 4) == 0) n = 0;
        result_stall <= (n != 0);
      end else begin
        n--;
        result_stall <= (n != 0);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  // valid stays high after the accepting edge; the next gap or drain drops it
  task automatic send(logic [31:0] t, logic [15:0] mv, bit ok, logic [7:0] lvl, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    if ($urandom_range(0, 5) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    sample <= '{time_ms: t, battery_millivolts: mv, sample_ok: ok, backlight_level: lvl};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // mostly well-formed stretch: steady level, time advancing, voltage drifting, with an occasional random word
  task automatic run_trend(int count, int slope, int step_ms);
    int v;
    for (int k = 0; k < count; k++) begin
      clock_ms = clock_ms + step_ms + $urandom_range(0, 500);
      v = base_mv + slope * k + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      if ($urandom_range(0, 40) == 0)
        send(clock_ms, 16'($urandom), 1'($urandom), cur_level, 1'b1);
      else send(clock_ms, v[15:0], 1'b1, cur_level, 1'b1);
    end
    base_mv = 16'(int'(base_mv) + slope * count);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: first level, level changes, extremes, invalid runs, wrapped time
    send(32'd0, 16'd0, 1'b0, 8'd0, 1'b0);
    send(32'd100, 16'hFFFF, 1'b1, 8'd0, 1'b0);
    send(32'd200, 16'd3000, 1'b1, 8'd0, 1'b0);
    send(32'd300, 16'd4400, 1'b1, 8'd0, 1'b0);
    send(32'd400, 16'd2999, 1'b1, 8'd0, 1'b0);
    send(32'd20400, 16'd3500, 1'b0, 8'd0, 1'b0);
    send(32'd20500, 16'd3500, 1'b1, 8'hFF, 1'b0);
    send(32'd80000, 16'd3600, 1'b1, 8'hFF, 1'b0);
    send(32'hFFFF_FF00, 16'd3700, 1'b1, 8'hFF, 1'b0);
    send(32'h0000_0100, 16'd3710, 1'b1, 8'hFF, 1'b0);
    send(32'hFFFF_FFFF, 16'd4400, 1'b1, 8'h55, 1'b0);
    send(32'h0000_2000, 16'd4000, 1'b1, 8'hAA, 1'b0);
    drain();

    reg_write(REG_MIN_MV, 32'd0);
    reg_write(REG_MAX_MV, 32'd65535);
    reg_write(REG_FAILSAFE, 32'd0);
    reg_write(REG_CHG_SETTLE, 32'd0);
    reg_write(REG_NRM_SETTLE, 32'd0);
    clock_ms = 32'h0000_3000;
    send(clock_ms, 16'd0, 1'b1, 8'hAA, 1'b0);
    send(clock_ms + 1, 16'hFFFF, 1'b1, 8'hAA, 1'b0);
    send(clock_ms + 2, 16'd5, 1'b0, 8'hAA, 1'b0);
    send(clock_ms + 3, 16'd5, 1'b0, 8'hAA, 1'b0);
    drain();

    // fill-up pressure: receiver holds off while samples keep coming
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      run_trend(12, 0, 2000);
    join
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          reg_write(REG_MIN_MV, 32'd3000); reg_write(REG_MAX_MV, 32'd4400);
          reg_write(REG_FAILSAFE, 32'd10000);
          reg_write(REG_CHG_SETTLE, 32'd15000); reg_write(REG_NRM_SETTLE, 32'd45000);
        end
        1: begin
          reg_write(REG_CHG_SETTLE, 32'd600000); reg_write(REG_NRM_SETTLE, 32'd5000);
          reg_write(REG_FAILSAFE, 32'd600000);
        end
        2: begin
          reg_write(REG_MIN_MV, 32'd65535); reg_write(REG_MAX_MV, 32'd0);
        end
        3: begin
          reg_write(REG_MIN_MV, 32'd3000); reg_write(REG_MAX_MV, 32'd4400);
          reg_write(REG_NRM_SETTLE, 32'd600000); reg_write(REG_CHG_SETTLE, 32'd2000);
          reg_write(REG_FAILSAFE, 32'd3000);
        end
        default: begin
          reg_write(REG_MIN_MV, $urandom_range(2500, 3200));
          reg_write(REG_MAX_MV, $urandom_range(4200, 65535));
          reg_write(REG_FAILSAFE, $urandom_range(0, 600000));
          reg_write(REG_CHG_SETTLE, $urandom_range(0, 20000));
          reg_write(REG_NRM_SETTLE, $urandom_range(0, 20000));
        end
      endcase
      for (int r = 0; r < 4; r++) begin
        base_mv = 16'($urandom_range(3400, 3900));
        if ($urandom_range(0, 2) == 0) cur_level = 8'($urandom);
        run_trend(6, 0, 1000);
        run_trend(12, 4, 3000);
        run_trend(6, -9, 3000);
        // invalid run that can reach the fail-safe time in some phases
        for (int k = 0; k < 3; k++) begin
          clock_ms = clock_ms + $urandom_range(0, 8000);
          send(clock_ms, 16'($urandom), 1'b0, cur_level, 1'b1);
        end
      end
      drain();
    end
    drain();
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
